// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the label table RTL.
// Needs nothing else; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LTNR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LTNR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTNR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LTNR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/ltnr_pkg.sv -----
// Types and codes for the label table with nexthop reference events.
// Depends on nothing; used by the interfaces and the top level.
package ltnr_pkg;
	localparam int INDEX_W   = 20;
	localparam int LABEL_W   = 20;
	localparam int NEXTHOP_W = 16;
	localparam int KIND_W    = 2;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_RESET = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] EV_REF   = 2'd1;
	localparam logic [KIND_W-1:0] EV_DEREF = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN_OLD,
		ST_WRITE,
		ST_SCAN_NEW,
		ST_EMIT1,
		ST_EMIT2
	} state_t;
endpackage

// ----- rtl/core/ltnr_ifs.sv -----
// Request and result channels of the label table, valid/ready handshake.
// Depends on ltnr_pkg for the field widths.
interface ltnr_req_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic [ltnr_pkg::INDEX_W-1:0]    entry_index;
	logic                            unicast_flag;
	logic [ltnr_pkg::LABEL_W-1:0]    new_label;
	logic [ltnr_pkg::NEXTHOP_W-1:0]  nexthop_id;

	modport source (output valid, output operation, output entry_index, output unicast_flag,
		output new_label, output nexthop_id, input ready);
	modport sink (input valid, input operation, input entry_index, input unicast_flag,
		input new_label, input nexthop_id, output ready);
endinterface

interface ltnr_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic [ltnr_pkg::KIND_W-1:0]     event_kind;
	logic                            event_unicast;
	logic [ltnr_pkg::NEXTHOP_W-1:0]  event_nexthop;
	logic                            last_result;

	modport source (output valid, output status, output event_kind, output event_unicast,
		output event_nexthop, output last_result, input ready);
	modport sink (input valid, input status, input event_kind, input event_unicast,
		input event_nexthop, input last_result, output ready);
endinterface

// ----- rtl/core/ltnr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ltnr_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/label_table_nexthop_refs.sv -----
// Label table with nexthop reference events. After reset a clearing pass over all TABLE_ENTRIES
// entries runs before the first request is taken. An index outside the table goes straight to
// its result; any other request reads its entry, scans the table once if that entry was valid,
// writes it and, for a set, scans once more; a set that both releases and references a nexthop
// gives a second result word. The scans read the table through the single RAM read port.
// Reset is asynchronous, active low. Depends on ltnr_pkg, ltnr_ifs, ltnr_ram, assert_macros.svh.
`include "assert_macros.svh"

module label_table_nexthop_refs #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int NEXTHOP_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	ltnr_req_if.sink          req,
	ltnr_rsp_if.source        rsp
);
	localparam int IDX_W     = $clog2(TABLE_ENTRIES);
	localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
	localparam int IN_W      = ltnr_pkg::INDEX_W;
	localparam int LBL_W     = ltnr_pkg::LABEL_W;
	localparam int NH_OUT_W  = ltnr_pkg::NEXTHOP_W;
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
	localparam logic [IN_W:0]    LIMIT    = (IN_W + 1)'(TABLE_ENTRIES);

	typedef struct packed {
		logic                    valid;
		logic                    unicast;
		logic [LBL_W-1:0]        label;
		logic [NEXTHOP_BITS-1:0] nexthop;
	} entry_t;

	ltnr_pkg::state_t state_q, state_d;

	logic                    op_q;
	logic [IDX_W-1:0]        slot_q;
	logic                    uni_q;
	logic [LBL_W-1:0]        label_q;
	logic [NEXTHOP_BITS-1:0] nh_q;
	logic                    nf_q;
	logic                    old_uni_q;
	logic [NEXTHOP_BITS-1:0] old_nh_q;
	logic                    deref_q;
	logic                    ref_q;
	logic                    shared_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_addr_s1;

	logic                    rsp_valid_q;
	logic                    status_q;
	logic [1:0]              kind_q;
	logic                    ev_uni_q;
	logic [NH_OUT_W-1:0]     ev_nh_q;
	logic                    last_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	entry_t                  mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	entry_t                  mem_rdata;

	logic                    accept;
	logic                    in_range;
	logic                    out_free;
	logic                    scan_start;
	logic                    scan_issue;
	logic                    scan_done;
	logic                    key_uni;
	logic [NEXTHOP_BITS-1:0] key_nh;
	logic                    hit;
	logic                    load_out;
	logic                    nx_status;
	logic [1:0]              nx_kind;
	logic                    nx_uni;
	logic [NH_OUT_W-1:0]     nx_nh;
	logic                    nx_last;

	ltnr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == ltnr_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = {1'b0, req.entry_index} < LIMIT;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign scan_done = (cnt_q == CNT_END) && !rd_vld_s1;

	assign key_uni = (state_q == ltnr_pkg::ST_SCAN_OLD) ? old_uni_q : uni_q;
	assign key_nh  = (state_q == ltnr_pkg::ST_SCAN_OLD) ? old_nh_q : nh_q;
	assign hit = rd_vld_s1 && mem_rdata.valid && (rd_addr_s1 != slot_q)
		&& (mem_rdata.unicast == key_uni) && (mem_rdata.nexthop == key_nh);

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = slot_q;
		mem_wdata  = '0;
		mem_raddr  = slot_q;
		scan_start = 1'b0;
		scan_issue = 1'b0;
		load_out   = 1'b0;
		nx_status  = ltnr_pkg::STATUS_OK;
		nx_kind    = ltnr_pkg::EV_NONE;
		nx_uni     = 1'b0;
		nx_nh      = '0;
		nx_last    = 1'b1;
		case (state_q)
			ltnr_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[IDX_W-1:0];
				if (cnt_q == CNT_LAST) begin
					state_d = ltnr_pkg::ST_IDLE;
				end
			end
			ltnr_pkg::ST_IDLE: begin
				mem_raddr = req.entry_index[IDX_W-1:0];
				if (accept) begin
					state_d = in_range ? ltnr_pkg::ST_READ : ltnr_pkg::ST_EMIT1;
				end
			end
			ltnr_pkg::ST_READ: begin
				if (mem_rdata.valid) begin
					scan_start = 1'b1;
					state_d    = ltnr_pkg::ST_SCAN_OLD;
				end else begin
					state_d = ltnr_pkg::ST_WRITE;
				end
			end
			ltnr_pkg::ST_SCAN_OLD, ltnr_pkg::ST_SCAN_NEW: begin
				if (cnt_q != CNT_END) begin
					scan_issue = 1'b1;
					mem_raddr  = cnt_q[IDX_W-1:0];
				end else if (scan_done) begin
					state_d = (state_q == ltnr_pkg::ST_SCAN_OLD) ?
						ltnr_pkg::ST_WRITE : ltnr_pkg::ST_EMIT1;
				end
			end
			ltnr_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				if (op_q == ltnr_pkg::OP_SET) begin
					mem_wdata  = '{valid: 1'b1, unicast: uni_q, label: label_q, nexthop: nh_q};
					scan_start = 1'b1;
					state_d    = ltnr_pkg::ST_SCAN_NEW;
				end else begin
					state_d = ltnr_pkg::ST_EMIT1;
				end
			end
			ltnr_pkg::ST_EMIT1: begin
				nx_status = nf_q;
				nx_last   = !(deref_q && ref_q);
				if (deref_q) begin
					nx_kind = ltnr_pkg::EV_DEREF;
					nx_uni  = old_uni_q;
					nx_nh   = NH_OUT_W'(old_nh_q);
				end else if (ref_q) begin
					nx_kind = ltnr_pkg::EV_REF;
					nx_uni  = uni_q;
					nx_nh   = NH_OUT_W'(nh_q);
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = (deref_q && ref_q) ? ltnr_pkg::ST_EMIT2 : ltnr_pkg::ST_IDLE;
				end
			end
			ltnr_pkg::ST_EMIT2: begin
				nx_kind = ltnr_pkg::EV_REF;
				nx_uni  = uni_q;
				nx_nh   = NH_OUT_W'(nh_q);
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ltnr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ltnr_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ltnr_pkg::ST_CLEAR;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			shared_q    <= 1'b0;
			deref_q     <= 1'b0;
			ref_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (scan_start) begin
				cnt_q <= '0;
			end else if (scan_issue || (state_q == ltnr_pkg::ST_CLEAR)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (scan_start) begin
				shared_q <= 1'b0;
			end else if (hit) begin
				shared_q <= 1'b1;
			end
			if (accept) begin
				deref_q <= 1'b0;
				ref_q   <= 1'b0;
			end else if (scan_done && (state_q == ltnr_pkg::ST_SCAN_OLD)) begin
				deref_q <= !shared_q;
			end else if (scan_done && (state_q == ltnr_pkg::ST_SCAN_NEW)) begin
				ref_q <= !shared_q;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			op_q    <= req.operation;
			slot_q  <= req.entry_index[IDX_W-1:0];
			uni_q   <= req.unicast_flag;
			label_q <= req.new_label;
			nh_q    <= NEXTHOP_BITS'(req.nexthop_id);
			nf_q    <= in_range ? ltnr_pkg::STATUS_OK : ltnr_pkg::STATUS_NOT_FOUND;
		end
		if (state_q == ltnr_pkg::ST_READ) begin
			old_uni_q <= mem_rdata.unicast;
			old_nh_q  <= mem_rdata.nexthop;
		end
		if (load_out) begin
			status_q <= nx_status;
			kind_q   <= nx_kind;
			ev_uni_q <= nx_uni;
			ev_nh_q  <= nx_nh;
			last_q   <= nx_last;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.event_kind    = kind_q;
	assign rsp.event_unicast = ev_uni_q;
	assign rsp.event_nexthop = ev_nh_q;
	assign rsp.last_result   = last_q;

	`LTNR_ASSERT(a_nf_direct, clk, arst_n, accept && !in_range |=> (state_q == ltnr_pkg::ST_EMIT1) && nf_q, "out-of-table request did not go straight to its result")
	`LTNR_ASSERT(a_two_only_set, clk, arst_n, (deref_q && ref_q) |-> (op_q == ltnr_pkg::OP_SET), "two events pending for a reset request")
	`LTNR_ASSERT(a_scan_pipe, clk, arst_n, rd_vld_s1 |-> (state_q == ltnr_pkg::ST_SCAN_OLD || state_q == ltnr_pkg::ST_SCAN_NEW), "scan read returned outside a scan")
	`LTNR_ASSERT(a_nf_shape, clk, arst_n, rsp.valid && (rsp.status == ltnr_pkg::STATUS_NOT_FOUND) |-> (rsp.event_kind == ltnr_pkg::EV_NONE) && rsp.last_result, "not-found word carries an event")
endmodule
